### rtl/hbrm_pkg.sv
package hbrm_pkg;

  // Item kinds carried in the low bits of tuser
  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_CAND   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] REG_RATIO_Q8     = 2'd0;
  localparam logic [1:0] REG_MAX_DISTANCE = 2'd1;

  localparam logic [8:0] RATIO_RESET    = 9'd230;
  localparam logic [8:0] MAX_DIST_RESET = 9'd100;

  localparam logic [8:0] NO_DIST  = 9'd256;
  localparam logic [3:0] NO_LEVEL = 4'd15;

  localparam logic [1:0] LAST_WORD = 2'd3;

  localparam int MAX_FEATURES = 2048;
  localparam int NUM_LEVELS   = 8;

  // One classified item as it travels from the front to the back
  typedef struct packed {
    cmd_t        kind;
    logic [1:0]  sel;
    logic [63:0] word;
    logic [10:0] idx;
    logic [2:0]  lvl;
    logic        skip;
  } entry_t;

  // Bit count of a 64-bit word, by pairs, nibbles, then byte sums
  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
    logic [63:0] v4;
    logic [63:0] v5;
    logic [63:0] v6;
    v1 = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    v2 = (v1 & 64'h3333_3333_3333_3333) + ((v1 >> 2) & 64'h3333_3333_3333_3333);
    v3 = (v2 + (v2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    v4 = v3 + (v3 >> 8);
    v5 = v4 + (v4 >> 16);
    v6 = v5 + (v5 >> 32);
    return v6[6:0];
  endfunction

endpackage

### rtl/hbrm_front.sv
module hbrm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [127:0]     s_tdata,
  input  logic [3:0]       s_tuser,
  output logic             push,
  output hbrm_pkg::entry_t push_entry,
  input  logic             queue_ready
);

  hbrm_pkg::cmd_t kind;
  logic [1:0]  sel;
  logic [10:0] idx;
  logic [2:0]  lvl;
  logic        taken;
  logic [15:0] crx;
  logic [15:0] qrx;
  logic [15:0] rad;
  logic [15:0] query_right;
  logic [15:0] radius;
  logic [15:0] x_err;
  logic        out_of_window;
  logic        out_of_range;
  logic        accept;

  // Unpack the beat
  assign kind  = hbrm_pkg::cmd_t'(s_tuser[1:0]);
  assign sel   = s_tuser[3:2];
  assign idx   = s_tdata[74:64];
  assign lvl   = s_tdata[77:75];
  assign taken = s_tdata[78];
  assign crx   = s_tdata[94:79];
  assign qrx   = s_tdata[110:95];
  assign rad   = s_tdata[126:111];

  assign s_tready = queue_ready;
  assign accept   = s_tvalid && s_tready;

  // Latch the query's stereo x and radius
  always_ff @(posedge clk) begin
    if (rst) begin
      query_right <= '0;
      radius      <= '0;
    end else if (accept && kind == hbrm_pkg::CMD_QUERY) begin
      query_right <= qrx;
      radius      <= rad;
    end
  end

  // Classify candidates that must be dropped
  assign x_err = (query_right >= crx) ? (query_right - crx) : (crx - query_right);
  assign out_of_window = (crx != 16'd0) && (x_err > radius);
  assign out_of_range  = (32'(idx) >= hbrm_pkg::MAX_FEATURES) ||
                         (32'(lvl) >= hbrm_pkg::NUM_LEVELS);

  // Forward every meaningful beat to the queue
  assign push = accept && kind != hbrm_pkg::CMD_NONE;

  always_comb begin
    push_entry.kind = kind;
    push_entry.sel  = sel;
    push_entry.word = s_tdata[63:0];
    push_entry.idx  = idx;
    push_entry.lvl  = lvl;
    push_entry.skip = taken || out_of_window || out_of_range;
  end

endmodule

### rtl/hbrm_queue.sv
module hbrm_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hbrm_pkg::entry_t push_entry,
  output logic             in_ready,
  output logic             out_valid,
  output hbrm_pkg::entry_t out_entry,
  input  logic             pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hbrm_pkg::entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign in_ready  = count != FULL_CNT;
  assign out_valid = count != '0;
  assign out_entry = entries[rd_ptr];
  assign do_push   = push && in_ready;
  assign do_pop    = pop && out_valid;

  // Store the incoming entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/hbrm_back.sv
module hbrm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  hbrm_pkg::entry_t q_entry,
  output logic             q_pop,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [8:0]       cfg_data,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [47:0]      m_tdata
);

  logic        en;
  logic [8:0]  ratio_q8;
  logic [8:0]  max_distance;
  logic [63:0] query_desc [4];

  // Distance stage registers
  logic           a_valid;
  hbrm_pkg::cmd_t a_kind;
  logic           a_last;
  logic           a_skip;
  logic [2:0]     a_lvl;
  logic [10:0]    a_idx;
  logic [6:0]     a_pc;

  // Trackers
  logic [8:0]  partial;
  logic [8:0]  best_dist;
  logic [8:0]  second_dist;
  logic [3:0]  best_level;
  logic [3:0]  second_level;
  logic [10:0] best_index;
  logic [15:0] match_count;

  // Result register
  logic        res_matched;
  logic [10:0] res_index;
  logic [8:0]  res_best;
  logic [8:0]  res_second;
  logic [15:0] res_count;

  logic [9:0]  sum;
  logic [8:0]  cand_dist;
  logic [17:0] ratio_prod;
  logic        ratio_fail;
  logic        ok;
  logic [15:0] match_count_next;

  // Advance the whole pipe unless a result is stuck at the output
  assign en    = !m_tvalid || m_tready;
  assign q_pop = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_q8     <= hbrm_pkg::RATIO_RESET;
      max_distance <= hbrm_pkg::MAX_DIST_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == hbrm_pkg::REG_RATIO_Q8) begin
        ratio_q8 <= cfg_data;
      end else if (cfg_index == hbrm_pkg::REG_MAX_DISTANCE) begin
        max_distance <= cfg_data;
      end
    end
  end

  // Stage one: store query words, count differing bits of candidate words
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        query_desc[i] <= '0;
      end
    end else if (en) begin
      a_valid <= q_valid;
      if (q_valid && q_entry.kind == hbrm_pkg::CMD_QUERY) begin
        query_desc[q_entry.sel] <= q_entry.word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind <= q_entry.kind;
      a_last <= q_entry.sel == hbrm_pkg::LAST_WORD;
      a_skip <= q_entry.skip;
      a_lvl  <= q_entry.lvl;
      a_idx  <= q_entry.idx;
      a_pc   <= hbrm_pkg::popcount64(q_entry.word ^ query_desc[q_entry.sel]);
    end
  end

  // Stage two: accumulate with saturation
  assign sum       = {1'b0, partial} + {3'b000, a_pc};
  assign cand_dist = (sum > {1'b0, hbrm_pkg::NO_DIST}) ? hbrm_pkg::NO_DIST : sum[8:0];

  // Accept test for the finish beat
  assign ratio_prod = 18'(ratio_q8) * 18'(second_dist);
  assign ratio_fail = {1'b0, best_dist, 8'h00} > ratio_prod;
  assign ok = (best_level != hbrm_pkg::NO_LEVEL) && (best_dist <= max_distance) &&
              !((best_level == second_level) && ratio_fail);
  assign match_count_next = (ok && match_count != 16'hFFFF) ? match_count + 16'd1
                                                            : match_count;

  // Update the best two trackers and the counter
  always_ff @(posedge clk) begin
    if (rst) begin
      partial      <= '0;
      best_dist    <= hbrm_pkg::NO_DIST;
      second_dist  <= hbrm_pkg::NO_DIST;
      best_level   <= hbrm_pkg::NO_LEVEL;
      second_level <= hbrm_pkg::NO_LEVEL;
      best_index   <= '0;
      match_count  <= '0;
    end else if (en && a_valid) begin
      unique case (a_kind)
        hbrm_pkg::CMD_QUERY: begin
          partial      <= '0;
          best_dist    <= hbrm_pkg::NO_DIST;
          second_dist  <= hbrm_pkg::NO_DIST;
          best_level   <= hbrm_pkg::NO_LEVEL;
          second_level <= hbrm_pkg::NO_LEVEL;
          best_index   <= '0;
        end
        hbrm_pkg::CMD_CAND: begin
          if (!a_last) begin
            partial <= cand_dist;
          end else begin
            partial <= '0;
            if (!a_skip) begin
              if (cand_dist < best_dist) begin
                second_dist  <= best_dist;
                second_level <= best_level;
                best_dist    <= cand_dist;
                best_level   <= {1'b0, a_lvl};
                best_index   <= a_idx;
              end else if (cand_dist < second_dist) begin
                second_dist  <= cand_dist;
                second_level <= {1'b0, a_lvl};
              end
            end
          end
        end
        hbrm_pkg::CMD_FINISH: begin
          partial     <= '0;
          match_count <= match_count_next;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register, loaded on finish
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= a_valid && a_kind == hbrm_pkg::CMD_FINISH;
    end
  end

  always_ff @(posedge clk) begin
    if (en && a_valid && a_kind == hbrm_pkg::CMD_FINISH) begin
      res_matched <= ok;
      res_index   <= best_index;
      res_best    <= best_dist;
      res_second  <= second_dist;
      res_count   <= match_count_next;
    end
  end

  assign m_tdata = {2'b00, res_count, res_second, res_best, res_index, res_matched};

endmodule

### rtl/hamming_best_two_ratio_matcher_core.sv
// A finish beat is written into the queue, then passes the distance stage, and the tracker
// stage loads the output register and raises m_tvalid.
// Throughput: one beat per cycle while results are taken; a held result stops the back,
// and the QUEUE_DEPTH-entry queue takes beats until it fills, then s_tready drops.
// Reset clears the queue, trackers, match count and query words; registers take
// ratio_q8 = 230 and max_distance = 100.
module hamming_best_two_ratio_matcher_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // desc_word[63:0], cand_index[74:64], cand_level[77:75], cand_taken[78],
  // cand_right_x[94:79], query_right_x[110:95], window_radius[126:111], zero
  input  logic [127:0] s_tdata,
  // cmd[1:0], word_sel[3:2]
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // matched[0], match_index[11:1], best_distance[20:12],
  // second_distance[29:21], total_matches[45:30], zero
  output logic [47:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [8:0]   cfg_data
);

  logic             push;
  hbrm_pkg::entry_t push_entry;
  logic             queue_ready;
  logic             q_valid;
  hbrm_pkg::entry_t q_entry;
  logic             q_pop;

  assign cfg_ready = 1'b1;

  hbrm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .push        (push),
    .push_entry  (push_entry),
    .queue_ready (queue_ready)
  );

  hbrm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .in_ready   (queue_ready),
    .out_valid  (q_valid),
    .out_entry  (q_entry),
    .pop        (q_pop)
  );

  hbrm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
